/* design/ncc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared types and constants for the nearest-centroid colour classifier.
// ----------------------------------------------------------------------------
package ncc_pkg;

    localparam int CHAN_W = 12;
    localparam int SQ_W   = 2 * CHAN_W;
    localparam int DIST_W = SQ_W + 2;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;

    localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

    localparam logic REQ_LOAD     = 1'b0;
    localparam logic REQ_CLASSIFY = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] y;
        logic [CHAN_W-1:0] cb;
        logic [CHAN_W-1:0] cr;
    } colour_t;

    localparam int COLOUR_W = $bits(colour_t);

endpackage

/* design/ncc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ncc_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/ncc_dist.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_dist
// Two-stage squared-distance unit: absolute differences, then squares.
// The three squares are summed on the output side.
// ----------------------------------------------------------------------------
module ncc_dist #(
    parameter int AW = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_vld,
    input  logic [AW-1:0]         in_idx,
    input  ncc_pkg::colour_t      pix,
    input  ncc_pkg::colour_t      cent,
    output logic                  busy,
    output logic                  out_vld,
    output logic [AW-1:0]         out_idx,
    output logic [ncc_pkg::DIST_W-1:0] out_dist
);
    import ncc_pkg::*;

    logic              s1_vld_reg, s1_vld_next;
    logic [AW-1:0]     s1_idx_reg;
    logic [CHAN_W-1:0] dy_reg, dcb_reg, dcr_reg;
    logic [CHAN_W-1:0] dy_next, dcb_next, dcr_next;

    logic              s2_vld_reg;
    logic [AW-1:0]     s2_idx_reg;
    logic [SQ_W-1:0]   sy_reg, scb_reg, scr_reg;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    always_comb
    begin
        s1_vld_next = in_vld;
        dy_next     = abs_diff(pix.y, cent.y);
        dcb_next    = abs_diff(pix.cb, cent.cb);
        dcr_next    = abs_diff(pix.cr, cent.cr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= in_idx;
        dy_reg     <= dy_next;
        dcb_reg    <= dcb_next;
        dcr_reg    <= dcr_next;
        s2_idx_reg <= s1_idx_reg;
        sy_reg     <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        scb_reg    <= SQ_W'(dcb_reg) * SQ_W'(dcb_reg);
        scr_reg    <= SQ_W'(dcr_reg) * SQ_W'(dcr_reg);
    end

    assign busy     = s1_vld_reg | s2_vld_reg;
    assign out_vld  = s2_vld_reg;
    assign out_idx  = s2_idx_reg;
    assign out_dist = DIST_W'(sy_reg) + DIST_W'(scb_reg) + DIST_W'(scr_reg);

endmodule

/* design/nearest_centroid_color_classifier_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_color_classifier_core
// Classify: with n = cluster_count capped at MAX_CLUSTERS, a classify beat
// reads n centroids from the table RAM, one a cycle, and holds the input
// stalled until its result is placed in the output register, which waits
// until that register is free. Loads: one per cycle while no classify runs.
// Reset: control clears, cluster_count returns to 16; table RAM is not cleared.
// ----------------------------------------------------------------------------
module nearest_centroid_color_classifier_core #(
    parameter int MAX_CLUSTERS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [ncc_pkg::CNT_W-1:0]   cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [ncc_pkg::IDX_W-1:0]   entry_index,
    input  logic [ncc_pkg::CHAN_W-1:0]  chan_y,
    input  logic [ncc_pkg::CHAN_W-1:0]  chan_cb,
    input  logic [ncc_pkg::CHAN_W-1:0]  chan_cr,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ncc_pkg::IDX_W-1:0]   class_index
);
    import ncc_pkg::*;

    localparam int AW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CW  = $clog2(MAX_CLUSTERS + 1);
    localparam int EW  = (AW > IDX_W) ? AW : IDX_W;
    localparam int SW  = (CW > CNT_W) ? CW : CNT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     addr_reg, addr_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    colour_t           pix_reg;
    logic [AW-1:0]     best_reg, best_next;
    logic [DIST_W-1:0] best_dist_reg, best_dist_next;
    logic              have_reg, have_next;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  class_index_reg, class_index_next;

    logic              in_fire;
    logic [EW-1:0]     idx_ext;
    logic              load_ok;
    logic              ram_we;
    colour_t           ram_wdata;
    colour_t           cent;
    logic [SW-1:0]     count_ext;
    logic              issue;
    logic              d_busy;
    logic              d_vld;
    logic [AW-1:0]     d_idx;
    logic [DIST_W-1:0] d_dist;
    logic [EW-1:0]     best_ext;

    assign in_fire   = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign idx_ext   = EW'(entry_index);
    assign load_ok   = ({1'b0, idx_ext} < (EW + 1)'(MAX_CLUSTERS));
    assign ram_we    = in_fire && (req_type == REQ_LOAD) && load_ok;
    assign ram_wdata = '{y: chan_y, cb: chan_cb, cr: chan_cr};
    assign count_ext = SW'(count_reg);
    assign issue     = (state_reg == ST_SCAN) && (addr_reg < cnt_reg);
    assign best_ext  = EW'(best_reg);

    ncc_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (MAX_CLUSTERS),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_ext[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (addr_reg[AW-1:0]),
        .rdata (cent)
    );

    ncc_dist #(
        .AW (AW)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (rd_vld_reg),
        .in_idx   (rd_idx_reg),
        .pix      (pix_reg),
        .cent     (cent),
        .busy     (d_busy),
        .out_vld  (d_vld),
        .out_idx  (d_idx),
        .out_dist (d_dist)
    );

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        cnt_next         = cnt_reg;
        addr_next        = addr_reg;
        rd_vld_next      = issue;
        rd_idx_next      = addr_reg[AW-1:0];
        best_next        = best_reg;
        best_dist_next   = best_dist_reg;
        have_next        = have_reg;
        out_valid_next   = out_valid_reg;
        class_index_next = class_index_reg;

        if (cfg_wr_en)
        begin
            count_next = cfg_wr_data;
        end

        // drop the result beat once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (d_vld && (!have_reg || (d_dist < best_dist_reg)))
        begin
            best_next      = d_idx;
            best_dist_next = d_dist;
            have_next      = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (req_type == REQ_CLASSIFY))
                begin
                    addr_next = '0;
                    best_next = '0;
                    have_next = 1'b0;
                    if (count_ext > SW'(MAX_CLUSTERS))
                    begin
                        cnt_next = CW'(MAX_CLUSTERS);
                    end
                    else
                    begin
                        cnt_next = CW'(count_ext);
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    addr_next = addr_reg + 1'b1;
                end
                else if (!rd_vld_reg && !d_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    class_index_next = best_ext[IDX_W-1:0];
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= CNT_RESET;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
            addr_reg      <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
            have_reg      <= have_next;
            addr_reg      <= addr_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (req_type == REQ_CLASSIFY))
        begin
            pix_reg <= ram_wdata;
        end
        rd_idx_reg      <= rd_idx_next;
        best_reg        <= best_next;
        best_dist_reg   <= best_dist_next;
        class_index_reg <= class_index_next;
    end

    assign out_valid   = out_valid_reg;
    assign class_index = class_index_reg;

endmodule

/* design/ncc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_checker
// Port-level checks for the classifier core, bound into every core instance.
// ----------------------------------------------------------------------------
module ncc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        req_type,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [ncc_pkg::IDX_W-1:0]   class_index
);
    import ncc_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(class_index))
        else $error("result beat changed while stalled");

    // a classify beat blocks the input while the scan runs
    a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_CLASSIFY) |=> in_stall)
        else $error("input not stalled after classify beat");

    // a load beat leaves the input open
    a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_LOAD) |=> !in_stall)
        else $error("input stalled after load beat");

    // a new result appears exactly as the scan releases the input
    a_result_release: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $fell(in_stall))
        else $error("result beat without end of scan");

endmodule

bind nearest_centroid_color_classifier_core ncc_checker u_ncc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .class_index (class_index)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest-centroid colour classifier. A directed
// table fills the centroid table and probes exact hits, ties and channel
// extremes. Random load and classify beats then follow under several cluster
// counts, zero and oversized counts among them. Every class index is checked
// in order, against the table's expected class where the row gives one and
// otherwise against a behavioural nearest-centroid search.
module tb_top;
    import ncc_pkg::*;

    localparam int MAX_CLUSTERS  = 16;
    localparam int HALF_PERIOD   = 10;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_BEATS   = 96;
    localparam int NUM_PHASES    = 8;
    localparam int DIR_ROWS      = 24;

    localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

    typedef struct packed {
        logic              req;
        logic [IDX_W-1:0]  idx;
        logic [CHAN_W-1:0] y;
        logic [CHAN_W-1:0] cb;
        logic [CHAN_W-1:0] cr;
        logic              fixed;
        logic [IDX_W-1:0]  want;
    } stim_row_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]   cfg_wr_data = '0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic               req_type    = REQ_LOAD;
    logic [IDX_W-1:0]   entry_index = '0;
    logic [CHAN_W-1:0]  chan_y      = '0;
    logic [CHAN_W-1:0]  chan_cb     = '0;
    logic [CHAN_W-1:0]  chan_cr     = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [IDX_W-1:0]   class_index;

    colour_t            centroid_model [MAX_CLUSTERS];
    logic [CNT_W-1:0]   count_model = CNT_RESET;
    logic [IDX_W-1:0]   class_due [$];
    int unsigned        errors       = 0;
    bit                 gap_free     = 1'b0;
    bit                 stall_free   = 1'b0;
    bit                 hold_off_req = 1'b0;

    // Entries 1..11 form a grey ramp; entry 12 duplicates entry 3 for the tie.
    stim_row_t dir_tab [DIR_ROWS] = '{
        '{REQ_LOAD,     4'd0,  12'd0,    12'd0,    12'd0,    1'b0, 4'd0},
        '{REQ_LOAD,     4'd1,  12'd272,  12'd272,  12'd272,  1'b0, 4'd0},
        '{REQ_LOAD,     4'd2,  12'd544,  12'd544,  12'd544,  1'b0, 4'd0},
        '{REQ_LOAD,     4'd3,  12'd816,  12'd816,  12'd816,  1'b0, 4'd0},
        '{REQ_LOAD,     4'd4,  12'd1088, 12'd1088, 12'd1088, 1'b0, 4'd0},
        '{REQ_LOAD,     4'd5,  12'd1360, 12'd1360, 12'd1360, 1'b0, 4'd0},
        '{REQ_LOAD,     4'd6,  12'd1632, 12'd1632, 12'd1632, 1'b0, 4'd0},
        '{REQ_LOAD,     4'd7,  12'd1904, 12'd1904, 12'd1904, 1'b0, 4'd0},
        '{REQ_LOAD,     4'd8,  12'd2176, 12'd2176, 12'd2176, 1'b0, 4'd0},
        '{REQ_LOAD,     4'd9,  12'd2448, 12'd2448, 12'd2448, 1'b0, 4'd0},
        '{REQ_LOAD,     4'd10, 12'd2720, 12'd2720, 12'd2720, 1'b0, 4'd0},
        '{REQ_LOAD,     4'd11, 12'd2992, 12'd2992, 12'd2992, 1'b0, 4'd0},
        '{REQ_LOAD,     4'd12, 12'd816,  12'd816,  12'd816,  1'b0, 4'd0},
        '{REQ_LOAD,     4'd13, 12'd4095, 12'd0,    12'd4095, 1'b0, 4'd0},
        '{REQ_LOAD,     4'd14, 12'd0,    12'd4095, 12'd0,    1'b0, 4'd0},
        '{REQ_LOAD,     4'd15, 12'd4095, 12'd4095, 12'd4095, 1'b0, 4'd0},
        '{REQ_CLASSIFY, 4'd9,  12'd0,    12'd0,    12'd0,    1'b1, 4'd0},
        '{REQ_CLASSIFY, 4'd0,  12'd4095, 12'd4095, 12'd4095, 1'b1, 4'd15},
        '{REQ_CLASSIFY, 4'd15, 12'd816,  12'd816,  12'd816,  1'b1, 4'd3},
        '{REQ_CLASSIFY, 4'd5,  12'd408,  12'd408,  12'd408,  1'b1, 4'd1},
        '{REQ_CLASSIFY, 4'd10, 12'd4095, 12'd0,    12'd4095, 1'b1, 4'd13},
        '{REQ_CLASSIFY, 4'd3,  12'd0,    12'd4095, 12'd0,    1'b1, 4'd14},
        '{REQ_CLASSIFY, 4'd12, 12'd4095, 12'd0,    12'd0,    1'b0, 4'd0},
        '{REQ_CLASSIFY, 4'd6,  12'd2000, 12'd100,  12'd3000, 1'b0, 4'd0}
    };

    nearest_centroid_color_classifier_core #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .entry_index (entry_index),
        .chan_y      (chan_y),
        .chan_cb     (chan_cb),
        .chan_cr     (chan_cr),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .class_index (class_index)
    );

    always #HALF_PERIOD clk = ~clk;

    // Mostly short bursts, now and then a long one.
    function automatic int unsigned burst_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    function automatic logic [DIST_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
        logic [DIST_W-1:0] diff;
        diff = (a >= b) ? a - b : b - a;
        return diff * diff;
    endfunction

    // Exhaustive scan over the entries in use; strict compare keeps the lowest index.
    function automatic logic [IDX_W-1:0] nearest_entry(input colour_t px);
        int unsigned       n;
        logic [DIST_W-1:0] dist_sum;
        logic [DIST_W-1:0] best_dist;
        logic [IDX_W-1:0]  best;
        n = (count_model > MAX_CLUSTERS) ? MAX_CLUSTERS : count_model;
        best = '0;
        best_dist = '0;
        for (int i = 0; i < n; i++)
        begin
            dist_sum = chan_sq(px.y, centroid_model[i].y)
                     + chan_sq(px.cb, centroid_model[i].cb)
                     + chan_sq(px.cr, centroid_model[i].cr);
            if (i == 0 || dist_sum < best_dist)
            begin
                best_dist = dist_sum;
                best = i[IDX_W-1:0];
            end
        end
        return best;
    endfunction

    function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 64)) - 32;
        if (v < 0)
            v = 0;
        if (v > int'(CHAN_MAX))
            v = int'(CHAN_MAX);
        return v[CHAN_W-1:0];
    endfunction

    // Offer one beat, hold it until taken, then update the table or queue the class.
    task automatic offer_beat(input logic req, input logic [IDX_W-1:0] idx,
                              input colour_t px, input bit fixed,
                              input logic [IDX_W-1:0] want);
        int unsigned gap;
        gap = (gap_free || $urandom_range(0, 99) < 55) ? 0 : burst_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        entry_index <= idx;
        chan_y      <= px.y;
        chan_cb     <= px.cb;
        chan_cr     <= px.cr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (req == REQ_LOAD)
            centroid_model[idx] = px;
        else
            class_due.push_back(fixed ? want : nearest_entry(px));
    endtask

    task automatic random_beat();
        colour_t          px;
        colour_t          ref_a;
        colour_t          ref_b;
        logic             req;
        logic [IDX_W-1:0] idx;
        int unsigned      pick;
        req   = ($urandom_range(0, 3) == 0) ? REQ_LOAD : REQ_CLASSIFY;
        idx   = IDX_W'($urandom_range(0, MAX_CLUSTERS - 1));
        ref_a = centroid_model[$urandom_range(0, MAX_CLUSTERS - 1)];
        ref_b = centroid_model[$urandom_range(0, MAX_CLUSTERS - 1)];
        pick  = $urandom_range(0, 9);
        if (pick < 4)
            px = '{CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom)};
        else if (pick < 6)
            px = ref_a;     // exact hit, or a duplicate entry when loading
        else if (pick < 8)
            px = '{nudge(ref_a.y), nudge(ref_a.cb), nudge(ref_a.cr)};
        else if (pick < 9)
            px = '{CHAN_W'((13'(ref_a.y) + 13'(ref_b.y)) >> 1),
                   CHAN_W'((13'(ref_a.cb) + 13'(ref_b.cb)) >> 1),
                   CHAN_W'((13'(ref_a.cr) + 13'(ref_b.cr)) >> 1)};
        else
            px = '{{CHAN_W{1'($urandom)}}, {CHAN_W{1'($urandom)}}, {CHAN_W{1'($urandom)}}};
        offer_beat(req, idx, px, 1'b0, '0);
    endtask

    // Write the count only once the block has gone quiet.
    task automatic write_count(input logic [CNT_W-1:0] value);
        while (class_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        count_model = value;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!stall_free && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat (burst_len()) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (class_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got class_index %0d",
                         $time, class_index);
                errors++;
            end
            else if (class_index !== class_due[0])
            begin
                $display("%0t: class_index mismatch, expected %0d, got %0d",
                         $time, class_due[0], class_index);
                errors++;
                void'(class_due.pop_front());
            end
            else
                void'(class_due.pop_front());
        end
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [CNT_W-1:0] next_count;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at the reset count: fill every entry before any classify.
        foreach (dir_tab[r])
            offer_beat(dir_tab[r].req, dir_tab[r].idx,
                       '{dir_tab[r].y, dir_tab[r].cb, dir_tab[r].cr},
                       dir_tab[r].fixed, dir_tab[r].want);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                1:       next_count = 5'd1;
                2:       next_count = 5'd0;     // nothing scanned, class 0
                3:       next_count = 5'd31;    // saturates to the table size
                4:       next_count = 5'd16;
                5:       next_count = 5'd17;
                6:       next_count = CNT_W'($urandom_range(2, 15));
                7:       next_count = CNT_W'($urandom_range(0, 31));
                default: next_count = CNT_RESET;
            endcase
            if (ph != 0)
                write_count(next_count);
            gap_free   = (ph % 3 == 1);
            stall_free = gap_free;
            // Back-to-back beats against a stalled output fill the block.
            if (ph == 4)
            begin
                gap_free     = 1'b1;
                hold_off_req = 1'b1;
            end
            repeat (PHASE_BEATS) random_beat();
            in_valid <= 1'b0;
        end

        while (class_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
